// File: sv/kskf_pkg.sv
// shared types, constants and microprogram for the keypoint kalman smoother
package kskf_pkg;

   // default configuration of the filter bank
   localparam int NUM_POINTS_DEF = 17;
   localparam int FRAC_BITS_DEF  = 12;

   // fixed field widths
   localparam int POINT_W  = 5;
   localparam int POS_W    = 20;
   localparam int WHOLE_W  = 12;
   localparam int COV_W    = 16;
   localparam int NOISE_W  = 16;
   localparam int POS_FRAC = 8;
   localparam int DIFF_W   = POS_W + 1;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // microprogram
   localparam int STEP_W = 4;

   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_LOAD,
      OP_DIV_FIRST,
      OP_DIV_STEP,
      OP_DIFF,
      OP_MUL_GAIN,
      OP_EST,
      OP_MUL_COV,
      OP_COV,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_BAD_INDEX,
      COND_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
      logic                done;
   } ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic bad_index;
      logic more;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [NOISE_W-1:0] x_r;
      logic [NOISE_W-1:0] x_q;
      logic [NOISE_W-1:0] y_r;
      logic [NOISE_W-1:0] y_q;
   } noise_type;

   // step addresses
   localparam logic [STEP_W-1:0] ADDR_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] ADDR_LOAD      = 4'd1;
   localparam logic [STEP_W-1:0] ADDR_DIV_FIRST = 4'd2;
   localparam logic [STEP_W-1:0] ADDR_DIV_STEP  = 4'd3;
   localparam logic [STEP_W-1:0] ADDR_DIFF      = 4'd4;
   localparam logic [STEP_W-1:0] ADDR_MUL_GAIN  = 4'd5;
   localparam logic [STEP_W-1:0] ADDR_EST       = 4'd6;
   localparam logic [STEP_W-1:0] ADDR_MUL_COV   = 4'd7;
   localparam logic [STEP_W-1:0] ADDR_COV       = 4'd8;
   localparam logic [STEP_W-1:0] ADDR_EMIT      = 4'd9;

   // control store: one word per step
   function automatic ctrl_type ucode(input logic [STEP_W-1:0] addr);
      ctrl_type w;
      w = '{op: OP_ACCEPT, cond: COND_NEVER, target: ADDR_IDLE, done: 1'b1};
      case (addr)
         ADDR_IDLE: begin
            w = '{op: OP_ACCEPT, cond: COND_NO_REQ, target: ADDR_IDLE, done: 1'b0};
         end
         ADDR_LOAD: begin
            w = '{op: OP_LOAD, cond: COND_BAD_INDEX, target: ADDR_EMIT, done: 1'b0};
         end
         ADDR_DIV_FIRST: begin
            w = '{op: OP_DIV_FIRST, cond: COND_NEVER, target: ADDR_IDLE, done: 1'b0};
         end
         ADDR_DIV_STEP: begin
            w = '{op: OP_DIV_STEP, cond: COND_MORE, target: ADDR_DIV_STEP, done: 1'b0};
         end
         ADDR_DIFF: begin
            w = '{op: OP_DIFF, cond: COND_NEVER, target: ADDR_IDLE, done: 1'b0};
         end
         ADDR_MUL_GAIN: begin
            w = '{op: OP_MUL_GAIN, cond: COND_NEVER, target: ADDR_IDLE, done: 1'b0};
         end
         ADDR_EST: begin
            w = '{op: OP_EST, cond: COND_NEVER, target: ADDR_IDLE, done: 1'b0};
         end
         ADDR_MUL_COV: begin
            w = '{op: OP_MUL_COV, cond: COND_NEVER, target: ADDR_IDLE, done: 1'b0};
         end
         ADDR_COV: begin
            w = '{op: OP_COV, cond: COND_NEVER, target: ADDR_IDLE, done: 1'b0};
         end
         ADDR_EMIT: begin
            w = '{op: OP_EMIT, cond: COND_OUT_BUSY, target: ADDR_EMIT, done: 1'b1};
         end
         default: begin
            w = '{op: OP_ACCEPT, cond: COND_NEVER, target: ADDR_IDLE, done: 1'b1};
         end
      endcase
      return w;
   endfunction

endpackage

// File: sv/keypoint_scalar_kalman_filter.sv
// top level: control registers, microcode sequencer and filter datapath
//
// Smooths keypoint coordinates with one scalar Kalman filter per keypoint
// and axis. Each request word names an axis, a keypoint and a Q12.8
// measurement; one response word carries the new Q12.8 estimate and its
// whole-pixel value truncated toward zero. Estimate and covariance start at
// 0 and 1.0 after reset. An index at or above NUM_POINTS changes no state
// and returns zero. Requests are handled one at a time; the gain divider
// produces one quotient bit per cycle. A new request is taken while the
// previous response still waits on rsp_ready. Measurement and process noise
// per axis are written through the register port: x R at 0x0, x Q at 0x4,
// y R at 0x8, y Q at 0xC. The user must write them only while no word is
// in flight; the block itself does not enforce this.
module keypoint_scalar_kalman_filter #(
   parameter int NUM_POINTS = kskf_pkg::NUM_POINTS_DEF,
   parameter int FRAC_BITS  = kskf_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic [kskf_pkg::POINT_W-1:0]           req_point_index,
   input  logic signed [kskf_pkg::POS_W-1:0]      req_measurement,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [kskf_pkg::POS_W-1:0]      rsp_estimate,
   output logic signed [kskf_pkg::WHOLE_W-1:0]    rsp_estimate_whole,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [kskf_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [kskf_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [kskf_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import kskf_pkg::*;

   localparam logic [1:0] REG_X_R = 2'd0;
   localparam logic [1:0] REG_X_Q = 2'd1;
   localparam logic [1:0] REG_Y_R = 2'd2;
   localparam logic [1:0] REG_Y_Q = 2'd3;

   // reset noise: 0.9 and 0.08 rounded to the covariance format
   localparam logic [NOISE_W-1:0] R_RESET = NOISE_W'((9 * (1 << FRAC_BITS) + 5) / 10);
   localparam logic [NOISE_W-1:0] Q_RESET = NOISE_W'((8 * (1 << FRAC_BITS) + 50) / 100);

   noise_type  noise_ff, noise_in;
   ctrl_type   ctrl;
   status_type status;
   logic       csr_wr;
   logic [1:0] csr_idx;

   // register write decode
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      noise_in = noise_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_X_R: noise_in.x_r = pwdata[NOISE_W-1:0];
            REG_X_Q: noise_in.x_q = pwdata[NOISE_W-1:0];
            REG_Y_R: noise_in.y_r = pwdata[NOISE_W-1:0];
            REG_Y_Q: noise_in.y_q = pwdata[NOISE_W-1:0];
            default: noise_in = noise_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= '{x_r: R_RESET, x_q: Q_RESET, y_r: R_RESET, y_q: Q_RESET};
      end else begin
         noise_ff <= noise_in;
      end
   end

   // register read back
   always_comb begin
      case (csr_idx)
         REG_X_R: prdata = CSR_DATA_W'(noise_ff.x_r);
         REG_X_Q: prdata = CSR_DATA_W'(noise_ff.x_q);
         REG_Y_R: prdata = CSR_DATA_W'(noise_ff.y_r);
         REG_Y_Q: prdata = CSR_DATA_W'(noise_ff.y_q);
         default: prdata = '0;
      endcase
   end

   // microcode sequencer
   kskf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // filter datapath
   kskf_datapath #(
      .NUM_POINTS (NUM_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .noise              (noise_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_point_index    (req_point_index),
      .req_measurement    (req_measurement),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_estimate       (rsp_estimate),
      .rsp_estimate_whole (rsp_estimate_whole)
   );

endmodule

// File: sv/kskf_sequencer.sv
// step counter and jump logic over the control store
module kskf_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  kskf_pkg::status_type status,
   output kskf_pkg::ctrl_type   ctrl
);
   import kskf_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              jump;

   // current control word
   assign ctrl = ucode(step_ff);

   // jump condition
   always_comb begin
      case (ctrl.cond)
         COND_NEVER:     jump = 1'b0;
         COND_NO_REQ:    jump = !status.req_fire;
         COND_BAD_INDEX: jump = status.bad_index;
         COND_MORE:      jump = status.more;
         COND_OUT_BUSY:  jump = status.out_busy;
         default:        jump = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (jump) begin
         step_in = ctrl.target;
      end else if (ctrl.done) begin
         step_in = ADDR_IDLE;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ADDR_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // a delivered word returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_EMIT && !status.out_busy) |=> step_ff == ADDR_IDLE)
      else $error("sequencer did not return to idle after emit");

   // step counter stays inside the control store
   assert property (@(posedge clock) disable iff (reset)
      step_ff <= ADDR_EMIT)
      else $error("step counter outside control store");

   // the divide loop always hands on to the difference step
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV_STEP && !status.more) |=> step_ff == ADDR_DIFF)
      else $error("divide loop exit went astray");

endmodule

// File: sv/kskf_datapath.sv
// state memory, gain divider, shared multiplier and result register
module kskf_datapath #(
   parameter int NUM_POINTS = kskf_pkg::NUM_POINTS_DEF,
   parameter int FRAC_BITS  = kskf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kskf_pkg::ctrl_type                  ctrl,
   output kskf_pkg::status_type                status,
   input  kskf_pkg::noise_type                 noise,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [kskf_pkg::POINT_W-1:0]        req_point_index,
   input  logic signed [kskf_pkg::POS_W-1:0]   req_measurement,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [kskf_pkg::POS_W-1:0]   rsp_estimate,
   output logic signed [kskf_pkg::WHOLE_W-1:0] rsp_estimate_whole
);
   import kskf_pkg::*;

   localparam int IDX_RAW = $clog2(NUM_POINTS);
   localparam int IDX_W   = (IDX_RAW < 1) ? 1 : ((IDX_RAW > POINT_W) ? POINT_W : IDX_RAW);
   localparam int ADDR_W  = IDX_W + 1;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int WORD_W  = POS_W + COV_W;
   localparam int GAIN_W  = FRAC_BITS + 1;
   localparam int DEN_W   = COV_W + 1;
   localparam int CNT_W   = $clog2(FRAC_BITS + 1);
   localparam int PROD_W  = DIFF_W + GAIN_W;
   localparam int STEP_PW = PROD_W - FRAC_BITS;
   localparam int SUM_W   = COV_W + 2;
   localparam int MAG_W   = POS_W + 1;
   localparam int WM_W    = MAG_W - POS_FRAC;

   localparam logic [COV_W-1:0] COV_ONE =
      (FRAC_BITS >= COV_W) ? {COV_W{1'b1}} : COV_W'(1 << FRAC_BITS);
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
   localparam logic [POINT_W+1:0] NUM_LIM = (POINT_W + 2)'(NUM_POINTS);

   // state memory and per-entry valid bits
   logic [WORD_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_vld_ff;

   // item registers
   logic                     kind_ff, kind_in;
   logic [POINT_W-1:0]       idx_ff, idx_in;
   logic signed [POS_W-1:0]  meas_ff, meas_in;
   logic signed [POS_W-1:0]  est_ff, est_in;
   logic [COV_W-1:0]         cov_ff, cov_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic [DIFF_W-1:0]        mag_ff, mag_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]   rsp_est_ff, rsp_est_in;
   logic signed [WHOLE_W-1:0] rsp_whole_ff, rsp_whole_in;

   logic                    fire;
   logic                    emit;
   logic [ADDR_W-1:0]       raddr;
   logic [ADDR_W-1:0]       waddr;
   logic [COV_W-1:0]        cov_ld;
   logic signed [POS_W-1:0] est_ld;
   logic [NOISE_W-1:0]      r_sel;
   logic [NOISE_W-1:0]      q_sel;
   logic                    first_ge;
   logic [DEN_W:0]          shifted;
   logic                    step_ge;
   logic [DEN_W:0]          step_sub;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]       mul_a;
   logic [GAIN_W-1:0]       mul_b;
   logic [STEP_PW-1:0]      upd;
   logic [STEP_PW-1:0]      est_ext;
   logic [STEP_PW-1:0]      nest;
   logic [SUM_W-1:0]        cov_sum;
   logic [COV_W-1:0]        ncov;
   logic [MAG_W-1:0]        est_mag;
   logic [WM_W-1:0]         whole_mag;
   logic [WM_W-1:0]         whole_s;

   // handshake and status
   assign req_ready = (ctrl.op == OP_ACCEPT);
   assign fire      = req_valid && req_ready;
   assign emit      = (ctrl.op == OP_EMIT) && !status.out_busy;

   assign status.req_fire  = fire;
   assign status.bad_index = {2'b00, idx_ff} >= NUM_LIM;
   assign status.more      = cnt_ff != CNT_W'(1);
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign raddr = {req_kind, req_point_index[IDX_W-1:0]};
   assign waddr = {kind_ff, idx_ff[IDX_W-1:0]};

   // entries never written read as the reset state
   assign cov_ld = rd_vld_ff ? rd_word_ff[COV_W-1:0] : COV_ONE;
   assign est_ld = rd_vld_ff ? rd_word_ff[WORD_W-1:COV_W] : '0;
   assign r_sel  = kind_ff ? noise.y_r : noise.x_r;
   assign q_sel  = kind_ff ? noise.y_q : noise.x_q;

   // restoring divider, one quotient bit per step
   assign first_ge = {1'b0, cov_ff} >= den_ff;
   assign shifted  = {rem_ff, 1'b0};
   assign step_ge  = shifted >= {1'b0, den_ff};
   assign step_sub = shifted - {1'b0, den_ff};

   assign diff = {meas_ff[POS_W-1], meas_ff} - {est_ff[POS_W-1], est_ff};

   // shared multiplier
   always_comb begin
      if (ctrl.op == OP_MUL_COV) begin
         mul_a = DIFF_W'(cov_ff);
         mul_b = GAIN_ONE - gain_ff;
      end else begin
         mul_a = mag_ff;
         mul_b = gain_ff;
      end
   end
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // estimate and covariance update
   assign upd     = prod_ff[PROD_W-1:FRAC_BITS];
   assign est_ext = {{(STEP_PW - POS_W){est_ff[POS_W-1]}}, est_ff};
   assign nest    = neg_ff ? (est_ext - upd) : (est_ext + upd);
   assign cov_sum = {2'b00, upd[COV_W-1:0]} + {2'b00, q_sel};
   assign ncov    = (|cov_sum[SUM_W-1:COV_W]) ? {COV_W{1'b1}} : cov_sum[COV_W-1:0];

   // whole pixels, truncated toward zero
   assign est_mag   = est_ff[POS_W-1] ? (MAG_W'(0) - {est_ff[POS_W-1], est_ff})
                                      : {1'b0, est_ff};
   assign whole_mag = est_mag[MAG_W-1:POS_FRAC];
   assign whole_s   = est_ff[POS_W-1] ? (WM_W'(0) - whole_mag) : whole_mag;

   // next-state for the working registers
   always_comb begin
      kind_in = kind_ff;
      idx_in  = idx_ff;
      meas_in = meas_ff;
      est_in  = est_ff;
      cov_in  = cov_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      gain_in = gain_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      case (ctrl.op)
         OP_ACCEPT: begin
            if (fire) begin
               kind_in = req_kind;
               idx_in  = req_point_index;
               meas_in = req_measurement;
            end
         end
         OP_LOAD: begin
            est_in = status.bad_index ? '0 : est_ld;
            cov_in = cov_ld;
            den_in = {1'b0, cov_ld} + {1'b0, r_sel};
         end
         OP_DIV_FIRST: begin
            rem_in  = first_ge ? ({1'b0, cov_ff} - den_ff) : {1'b0, cov_ff};
            gain_in = GAIN_W'(first_ge);
            cnt_in  = CNT_W'(FRAC_BITS);
         end
         OP_DIV_STEP: begin
            rem_in  = step_ge ? step_sub[DEN_W-1:0] : shifted[DEN_W-1:0];
            gain_in = {gain_ff[GAIN_W-2:0], step_ge};
            cnt_in  = cnt_ff - 1'b1;
         end
         OP_DIFF: begin
            neg_in = diff[DIFF_W-1];
            mag_in = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
            if (den_ff == '0) begin
               gain_in = '0;
            end
         end
         OP_EST: begin
            est_in = nest[POS_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // result register: a waiting word does not hold up the next item until it is ready to emit
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_whole_in = rsp_whole_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_est_in   = est_ff;
         rsp_whole_in = whole_s[WHOLE_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      meas_ff      <= meas_in;
      est_ff       <= est_in;
      cov_ff       <= cov_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      gain_ff      <= gain_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      rsp_est_ff   <= rsp_est_in;
      rsp_whole_ff <= rsp_whole_in;
      if (ctrl.op == OP_MUL_GAIN || ctrl.op == OP_MUL_COV) begin
         prod_ff <= prod_in;
      end
   end

   // state memory: read on accept, write back in the covariance step
   always_ff @(posedge clock) begin
      if (fire) begin
         rd_word_ff <= mem[raddr];
         rd_vld_ff  <= vld_ff[raddr];
      end
      if (ctrl.op == OP_COV) begin
         mem[waddr] <= {est_ff, ncov};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctrl.op == OP_COV) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_estimate       = rsp_est_ff;
   assign rsp_estimate_whole = rsp_whole_ff;

   // gain never exceeds one once the division is finished
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_MUL_GAIN) |-> gain_ff <= GAIN_ONE)
      else $error("gain above one");

   // partial remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV_STEP) |-> (rem_ff < den_ff || den_ff == '0))
      else $error("divider remainder out of range");

   // an emitted word is presented on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && rsp_est_ff == $past(est_ff))
      else $error("emitted word not presented");

endmodule

// File: sim/testbench.sv
// self-checking testbench for the keypoint kalman smoother with its own filter bank model
module testbench;
   import kskf_pkg::*;

   localparam int NUM_POINTS      = NUM_POINTS_DEF;
   localparam int FRAC_BITS       = FRAC_BITS_DEF;
   localparam int LATENCY         = FRAC_BITS + 9;
   localparam int ITEMS_PER_PHASE = 255;
   localparam int PHASE_COUNT     = 6;
   localparam int LIMIT_CYCLES    = 400_000;
   localparam int PROBE_COUNT     = 18;

   localparam longint unsigned COV_ONE = 64'd1 << FRAC_BITS;
   localparam longint unsigned COV_MAX = 64'd65535;

   localparam logic [NOISE_W-1:0] R_DEFAULT = 16'd3686;
   localparam logic [NOISE_W-1:0] Q_DEFAULT = 16'd328;

   localparam logic signed [POS_W-1:0] POS_MAX = 20'h7FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 20'h80000;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef enum int {
      REG_X_MEASURE,
      REG_X_PROCESS,
      REG_Y_MEASURE,
      REG_Y_PROCESS
   } noise_reg_e;

   typedef struct packed {
      logic signed [POS_W-1:0]   estimate;
      logic signed [WHOLE_W-1:0] whole;
   } coord_t;

   typedef struct packed {
      logic                      kind;
      logic [POINT_W-1:0]        point;
      logic signed [POS_W-1:0]   meas;
      logic                      typed;
      logic signed [POS_W-1:0]   estimate;
      logic signed [WHOLE_W-1:0] whole;
   } probe_row_t;

   // directed words from reset state; fixed answers only where obvious
   probe_row_t probe_table [PROBE_COUNT] = '{
      '{AXIS_X, 5'd0,  POS_MAX,       1'b1, 20'sd275839,  12'sd1077},
      '{AXIS_Y, 5'd16, POS_MIN,       1'b1, -20'sd275840, -12'sd1077},
      '{AXIS_X, 5'd17, 20'sd1000,     1'b1, 20'sd0,       12'sd0},
      '{AXIS_Y, 5'd31, -20'sd1,       1'b1, 20'sd0,       12'sd0},
      '{AXIS_X, 5'd31, POS_MIN,       1'b1, 20'sd0,       12'sd0},
      '{AXIS_X, 5'd1,  20'sd0,        1'b1, 20'sd0,       12'sd0},
      '{AXIS_X, 5'd0,  POS_MIN,       1'b0, 20'sd0,       12'sd0},
      '{AXIS_X, 5'd0,  POS_MAX,       1'b0, 20'sd0,       12'sd0},
      '{AXIS_Y, 5'd16, POS_MAX,       1'b0, 20'sd0,       12'sd0},
      '{AXIS_Y, 5'd5,  -20'sd1,       1'b0, 20'sd0,       12'sd0},
      '{AXIS_X, 5'd2,  20'sd255,      1'b0, 20'sd0,       12'sd0},
      '{AXIS_X, 5'd2,  -20'sd256,     1'b0, 20'sd0,       12'sd0},
      '{AXIS_Y, 5'd3,  20'sd1,        1'b0, 20'sd0,       12'sd0},
      '{AXIS_Y, 5'd3,  20'sd524032,   1'b0, 20'sd0,       12'sd0},
      '{AXIS_X, 5'd16, 20'sd12345,    1'b0, 20'sd0,       12'sd0},
      '{AXIS_Y, 5'd0,  -20'sd77777,   1'b0, 20'sd0,       12'sd0},
      '{AXIS_X, 5'd0,  POS_MAX,       1'b0, 20'sd0,       12'sd0},
      '{AXIS_Y, 5'd16, POS_MIN,       1'b0, 20'sd0,       12'sd0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_kind = 1'b0;
   logic [POINT_W-1:0]         req_point_index = '0;
   logic signed [POS_W-1:0]    req_measurement = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [POS_W-1:0]    rsp_estimate;
   logic signed [WHOLE_W-1:0]  rsp_estimate_whole;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   // model state: per axis noise, per axis and point estimate and covariance
   logic [NOISE_W-1:0]         measure_noise [2];
   logic [NOISE_W-1:0]         process_noise [2];
   logic signed [POS_W-1:0]    est_bank [2][NUM_POINTS];
   logic [COV_W-1:0]           cov_bank [2][NUM_POINTS];

   coord_t awaited_coords [$];
   int     failures = 0;
   int     send_idle_pct = 0;
   int     stall_pct = 0;

   keypoint_scalar_kalman_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_point_index    (req_point_index),
      .req_measurement    (req_measurement),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_estimate       (rsp_estimate),
      .rsp_estimate_whole (rsp_estimate_whole),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * 8);
      $display("RESULT: ERROR");
      $finish;
   end

   // one filter update: gain, new estimate, new covariance, whole pixels
   function automatic coord_t kalman_update(input logic axis, input logic [POINT_W-1:0] point,
                                            input logic signed [POS_W-1:0] meas);
      coord_t res;
      longint est, nest, diff, step, mag, whole;
      longint unsigned cov, den, gain, ncov;
      res = '0;
      if (point >= NUM_POINTS) return res;
      est  = est_bank[axis][point];
      cov  = cov_bank[axis][point];
      den  = cov + measure_noise[axis];
      gain = (den == 0) ? 64'd0 : (cov << FRAC_BITS) / den;
      diff = longint'(meas) - est;
      mag  = (diff < 0) ? -diff : diff;
      step = (mag * longint'(gain)) >> FRAC_BITS;
      nest = (diff < 0) ? est - step : est + step;
      ncov = (((COV_ONE - gain) * cov) >> FRAC_BITS) + process_noise[axis];
      if (ncov > COV_MAX) ncov = COV_MAX;
      est_bank[axis][point] = nest[POS_W-1:0];
      cov_bank[axis][point] = ncov[COV_W-1:0];
      mag   = (nest < 0) ? -nest : nest;
      whole = mag >> POS_FRAC;
      if (nest < 0) whole = -whole;
      res.estimate = nest[POS_W-1:0];
      res.whole    = whole[WHOLE_W-1:0];
      return res;
   endfunction

   // mostly near the current track, some full-range and extreme values
   function automatic logic signed [POS_W-1:0] pick_measurement(input logic axis,
                                                                input logic [POINT_W-1:0] point);
      logic signed [POS_W-1:0] base;
      int unsigned roll;
      int jitter;
      roll = $urandom_range(99);
      base = '0;
      if (point < NUM_POINTS) base = est_bank[axis][point];
      if (roll < 8) begin
         case ($urandom_range(3))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      if (roll < 35) return POS_W'($urandom);
      jitter = int'($urandom_range(4095)) - 2048;
      if (roll < 45) jitter = jitter * 64;
      return base + POS_W'(jitter);
   endfunction

   // offer one request word, record its expected answer on acceptance
   task automatic send_word(input logic axis, input logic [POINT_W-1:0] point,
                            input logic signed [POS_W-1:0] meas,
                            input logic typed, input coord_t typed_coord);
      coord_t predicted;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_kind        <= axis;
      req_point_index <= point;
      req_measurement <= meas;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = kalman_update(axis, point, meas);
      awaited_coords.push_back(typed ? typed_coord : predicted);
      @(negedge clock);
   endtask

   // stop sending and let every outstanding word come back
   task automatic settle_bank();
      req_valid <= 1'b0;
      while (awaited_coords.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   // register write then read back
   task automatic write_noise(input noise_reg_e index, input logic [NOISE_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[NOISE_W-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(index));
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (index)
         REG_X_MEASURE: measure_noise[AXIS_X] = value;
         REG_X_PROCESS: process_noise[AXIS_X] = value;
         REG_Y_MEASURE: measure_noise[AXIS_Y] = value;
         default:       process_noise[AXIS_Y] = value;
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[NOISE_W-1:0] !== value) begin
         $error("register %s readback: expected %0d, got %0d", index.name(), value,
                prdata[NOISE_W-1:0]);
         failures++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // response side back-pressure
   always @(negedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // compare each returned word with the oldest expected coordinate
   always @(posedge clock) begin
      coord_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (awaited_coords.size() == 0) begin
            $error("unexpected response word: estimate %0d", rsp_estimate);
            failures++;
         end else begin
            want = awaited_coords.pop_front();
            if (rsp_estimate !== want.estimate) begin
               $error("estimate: expected %0d, got %0d", want.estimate, rsp_estimate);
               failures++;
            end
            if (rsp_estimate_whole !== want.whole) begin
               $error("estimate_whole: expected %0d, got %0d", want.whole,
                      rsp_estimate_whole);
               failures++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic               axis;
      logic [POINT_W-1:0] point;
      logic [NOISE_W-1:0] setting [4];
      for (int a = 0; a < 2; a++) begin
         measure_noise[a] = R_DEFAULT;
         process_noise[a] = Q_DEFAULT;
         for (int p = 0; p < NUM_POINTS; p++) begin
            est_bank[a][p] = '0;
            cov_bank[a][p] = COV_W'(COV_ONE);
         end
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at default noise
      foreach (probe_table[i]) begin
         send_word(probe_table[i].kind, probe_table[i].point, probe_table[i].meas,
                   probe_table[i].typed, {probe_table[i].estimate, probe_table[i].whole});
      end
      settle_bank();

      // random phases, each under its own noise setting and idling pattern
      for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
         case (phase)
            1: setting = '{16'd1, 16'd0, 16'hFFFF, 16'hFFFF};
            2: setting = '{16'hFFFF, 16'hFFFF, 16'd1, 16'd0};
            3: setting = '{16'd0, 16'd0, 16'd0, 16'd0};
            4: setting = '{R_DEFAULT, Q_DEFAULT, R_DEFAULT, Q_DEFAULT};
            5: begin
               foreach (setting[k]) setting[k] = NOISE_W'($urandom);
            end
            default: begin
               setting[REG_X_MEASURE] = NOISE_W'($urandom_range(8192, 1));
               setting[REG_X_PROCESS] = NOISE_W'($urandom_range(1024));
               setting[REG_Y_MEASURE] = NOISE_W'($urandom_range(8192, 1));
               setting[REG_Y_PROCESS] = NOISE_W'($urandom_range(1024));
            end
         endcase
         for (int k = 0; k < 4; k++) write_noise(noise_reg_e'(k), setting[k]);

         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 71;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 71;
            end
            default: begin
               send_idle_pct = 17;
               stall_pct     = 17;
            end
         endcase

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            axis = $urandom_range(1);
            if ($urandom_range(15) == 0) begin
               point = POINT_W'($urandom_range(31, NUM_POINTS));
            end else begin
               point = POINT_W'($urandom_range(NUM_POINTS - 1));
            end
            send_word(axis, point, pick_measurement(axis, point), 1'b0, '0);
            // hold off mid-phase until the pipeline is empty
            if (n == ITEMS_PER_PHASE / 2) settle_bank();
         end
         settle_bank();
      end

      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
